// ===== design/grid_box_smoothing_3x3_unit_macros.svh =====
// Assertion macros used by the checker file of the grid box smoothing unit.
// Depends on nothing; included by the checker module.
`ifndef GRID_BOX_SMOOTHING_3X3_UNIT_MACROS_SVH
`define GRID_BOX_SMOOTHING_3X3_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define GBS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gbs assertion failed");

// Property checked on every clock edge, reset included.
`define GBS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gbs assertion failed");

`endif

// ===== design/gbs_pkg.sv =====
// Shared types and constants of the grid box smoothing unit.
// Depends on nothing; used by the column cell, the top level, the checkers and the testbench.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int ROWS_W     = 16;
    localparam int COLS_CFG_W = 9;
    localparam int IN_ROW_W   = ROWS_W + 1;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic emit;
        logic top_off;
        logic bot_off;
        logic left_off;
        logic right_off;
        logic last;
    } gbs_ctrl_t;

    typedef struct packed {
        logic row_top_off;
        logic row_bot_off;
        logic col_off;
    } gbs_cell_mask_t;

endpackage

// ===== design/gbs_line_buf.sv =====
// Two line memories holding the rows above the incoming one.
// Read data is registered; a write to the address being read is forwarded.
`timescale 1ns / 1ps

module gbs_line_buf #(
    parameter int MAX_COLS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
    input  logic signed [HEIGHT_BITS-1:0] wr_data,
    output logic signed [HEIGHT_BITS-1:0] older_q,
    output logic signed [HEIGHT_BITS-1:0] newer_q
);

    logic signed [HEIGHT_BITS-1:0] older_mem [MAX_COLS];
    logic signed [HEIGHT_BITS-1:0] newer_mem [MAX_COLS];
    logic                          bypass;

    assign bypass = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[wr_addr] <= newer_q;
            newer_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (bypass) begin
                older_q <= newer_q;
                newer_q <= wr_data;
            end else begin
                older_q <= older_mem[rd_addr];
                newer_q <= newer_mem[rd_addr];
            end
        end
    end

endmodule

// ===== design/gbs_col_cell.sv =====
// One column cell of the 3x3 window: holds three heights and passes them on.
// Depends on gbs_pkg for the cell mask type.
`timescale 1ns / 1ps

module gbs_col_cell #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic signed [HEIGHT_BITS-1:0] top_in,
    input  logic signed [HEIGHT_BITS-1:0] mid_in,
    input  logic signed [HEIGHT_BITS-1:0] bot_in,
    input  gbs_pkg::gbs_cell_mask_t       mask,
    output logic signed [HEIGHT_BITS-1:0] top_out,
    output logic signed [HEIGHT_BITS-1:0] mid_out,
    output logic signed [HEIGHT_BITS-1:0] bot_out,
    output logic signed [HEIGHT_BITS+1:0] col_sum
);

    logic signed [HEIGHT_BITS-1:0] top_reg;
    logic signed [HEIGHT_BITS-1:0] mid_reg;
    logic signed [HEIGHT_BITS-1:0] bot_reg;
    logic signed [HEIGHT_BITS+1:0] top_term;
    logic signed [HEIGHT_BITS+1:0] bot_term;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            top_reg <= top_in;
            mid_reg <= mid_in;
            bot_reg <= bot_in;
        end
    end

    assign top_out = top_reg;
    assign mid_out = mid_reg;
    assign bot_out = bot_reg;

    assign top_term = mask.row_top_off ? '0 : (HEIGHT_BITS+2)'(top_reg);
    assign bot_term = mask.row_bot_off ? '0 : (HEIGHT_BITS+2)'(bot_reg);

    always_comb begin
        if (mask.col_off) begin
            col_sum = '0;
        end else begin
            col_sum = top_term + (HEIGHT_BITS+2)'(mid_reg) + bot_term;
        end
    end

endmodule

// ===== design/gbs_div9.sv =====
// Signed division by nine, truncated toward zero, in two register stages.
// Uses a reciprocal multiply that is exact over the whole input range.
`timescale 1ns / 1ps

module gbs_div9 #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [HEIGHT_BITS+3:0] in_sum,
    input  logic                          in_last,
    output logic                          out_valid,
    output logic signed [HEIGHT_BITS-1:0] out_quot,
    output logic                          out_last
);

    localparam int MAG_W = HEIGHT_BITS + 3;
    localparam int SHIFT = MAG_W + 3;
    localparam int RCP_W = SHIFT - 2;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) / 64'd9) + 64'd1;
    localparam int PROD_W = MAG_W + RCP_W;

    logic                   a_valid_reg;
    logic                   a_neg_reg;
    logic                   a_last_reg;
    logic [MAG_W-1:0]       a_mag_reg;
    logic                   b_valid_reg;
    logic                   b_neg_reg;
    logic                   b_last_reg;
    logic [PROD_W-1:0]      b_prod_reg;
    logic signed [HEIGHT_BITS+3:0] neg_sum;
    logic [HEIGHT_BITS-1:0] quot_mag;

    assign neg_sum  = -in_sum;
    assign quot_mag = b_prod_reg[SHIFT +: HEIGHT_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_neg_reg  <= in_sum[HEIGHT_BITS+3];
            a_last_reg <= in_last;
            a_mag_reg  <= in_sum[HEIGHT_BITS+3] ? MAG_W'(neg_sum) : MAG_W'(in_sum);
            b_neg_reg  <= a_neg_reg;
            b_last_reg <= a_last_reg;
            b_prod_reg <= PROD_W'(a_mag_reg) * PROD_W'(RCP_W'(RECIP));
        end
    end

    assign out_valid = b_valid_reg;
    assign out_last  = b_last_reg;
    assign out_quot  = b_neg_reg ? -quot_mag : quot_mag;

endmodule

// ===== design/grid_box_smoothing_3x3_unit.sv =====
// Top level of the grid box smoothing unit: position control, window cells and output buffer.
// Depends on gbs_pkg, gbs_line_buf, gbs_col_cell and gbs_div9.
`timescale 1ns / 1ps

// Usage:
// Heights of a grid_rows x grid_cols grid enter on the s_ channel in raster order,
// one request per cycle while s_ready is high. Each result on the m_ channel is the
// sum of a cell and its neighbors inside the grid, divided by nine and truncated toward zero.
// A result belongs to the cell grid_cols + 1 requests earlier, so once a grid is
// complete the sender gives flush requests (s_kind = 1) to drain the final row;
// flush requests sent earlier are dropped. m_last marks the final cell.
// A result passes from the request that completes its neighborhood through the line
// memory read, window shift, column sum and two divider stages to the output register.
// The sustained rate is one request per cycle while the receiver keeps taking results.
// The output register has a skid stage, so requests are still taken while a result
// waits; once a second result is held in the skid stage, s_ready drops until the
// receiver takes the waiting result.
// Reset returns both registers to 1 and the grid position to its start; the line
// memories are not cleared. Register writes on the APB port restart the grid; the user
// must make them only while the block is idle, as the block does not enforce this.

module grid_box_smoothing_3x3_unit #(
    parameter int MAX_COLS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic signed [HEIGHT_BITS-1:0]       s_height,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [HEIGHT_BITS-1:0]       m_smoothed,
    output logic                                m_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gbs_pkg::PADDR_W-1:0]         paddr,
    input  logic [gbs_pkg::PDATA_W-1:0]         pwdata,
    output logic [gbs_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = COL_W + 1;
    localparam int ROWS_W   = gbs_pkg::ROWS_W;
    localparam int CFGC_W   = gbs_pkg::COLS_CFG_W;
    localparam int IN_ROW_W = gbs_pkg::IN_ROW_W;
    localparam int SUM_W    = HEIGHT_BITS + 4;

    logic [ROWS_W-1:0]   grid_rows_reg;
    logic [CFGC_W-1:0]   grid_cols_reg;
    logic                cfg_wr;

    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [ROWS_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;

    logic [ROWS_W-1:0]   rows_used;
    logic [CNT_W-1:0]    cols_used;
    logic [CNT_W-1:0]    in_col_inc;
    logic [CNT_W-1:0]    out_col_inc;
    logic                in_wrap;
    logic                out_wrap;
    logic                complete;
    logic                step_go;
    logic                adv;
    logic signed [HEIGHT_BITS-1:0] h_sel;
    gbs_pkg::gbs_ctrl_t  ctrl;

    logic                p1_valid_reg;
    logic signed [HEIGHT_BITS-1:0] p1_h_reg;
    logic [COL_W-1:0]    p1_addr_reg;
    gbs_pkg::gbs_ctrl_t  p1_ctrl_reg;

    logic signed [HEIGHT_BITS-1:0] older_q;
    logic signed [HEIGHT_BITS-1:0] newer_q;

    logic                p2_valid_reg;
    gbs_pkg::gbs_ctrl_t  p2_ctrl_reg;

    logic signed [HEIGHT_BITS-1:0] cell_top [3];
    logic signed [HEIGHT_BITS-1:0] cell_mid [3];
    logic signed [HEIGHT_BITS-1:0] cell_bot [3];
    logic signed [HEIGHT_BITS+1:0] cell_sum [3];
    gbs_pkg::gbs_cell_mask_t       cell_mask [3];
    logic                          shift_en;

    logic                p3_valid_reg;
    logic signed [SUM_W-1:0] p3_sum_reg;
    logic                p3_last_reg;

    logic                res_valid;
    logic signed [HEIGHT_BITS-1:0] res_quot;
    logic                res_last;

    logic                out_valid_reg;
    logic signed [HEIGHT_BITS-1:0] out_data_reg;
    logic                out_last_reg;
    logic                skid_valid_reg;
    logic signed [HEIGHT_BITS-1:0] skid_data_reg;
    logic                skid_last_reg;
    logic                pop;
    logic                push;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= ROWS_W'(1);
            grid_cols_reg <= CFGC_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                gbs_pkg::REG_GRID_ROWS: grid_rows_reg <= pwdata[ROWS_W-1:0];
                gbs_pkg::REG_GRID_COLS: grid_cols_reg <= pwdata[CFGC_W-1:0];
                default: grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            gbs_pkg::REG_GRID_ROWS: prdata = {(gbs_pkg::PDATA_W-ROWS_W)'(0), grid_rows_reg};
            gbs_pkg::REG_GRID_COLS: prdata = {(gbs_pkg::PDATA_W-CFGC_W)'(0), grid_cols_reg};
            default:                prdata = '0;
        endcase
    end

    // Grid position and window masks.
    assign rows_used = (grid_rows_reg == '0) ? ROWS_W'(1) : grid_rows_reg;

    always_comb begin
        if (grid_cols_reg == '0) begin
            cols_used = CNT_W'(1);
        end else if (32'(grid_cols_reg) > MAX_COLS) begin
            cols_used = CNT_W'(MAX_COLS);
        end else begin
            cols_used = CNT_W'(grid_cols_reg);
        end
    end

    assign adv         = !skid_valid_reg;
    assign s_ready     = adv;
    assign in_col_inc  = {1'b0, in_col_reg} + CNT_W'(1);
    assign out_col_inc = {1'b0, out_col_reg} + CNT_W'(1);
    assign in_wrap     = in_col_inc >= cols_used;
    assign out_wrap    = out_col_inc >= cols_used;
    assign complete    = in_row_reg >= {1'b0, rows_used};
    assign step_go     = s_valid && adv && !((s_kind == gbs_pkg::KIND_FLUSH) && !complete);
    assign h_sel       = complete ? '0 : s_height;

    always_comb begin
        ctrl.emit      = (in_row_reg >= IN_ROW_W'(2))
                      || ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));
        ctrl.top_off   = out_row_reg == '0;
        ctrl.bot_off   = ({1'b0, out_row_reg} + IN_ROW_W'(1)) >= {1'b0, rows_used};
        ctrl.left_off  = out_col_reg == '0;
        ctrl.right_off = out_wrap;
        ctrl.last      = ctrl.bot_off && out_wrap;
    end

    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (cfg_wr) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end else if (step_go) begin
            if (in_wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_W'(1);
            end else begin
                in_col_next = in_col_inc[COL_W-1:0];
            end
            if (ctrl.emit) begin
                if (ctrl.last) begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end else if (out_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROWS_W'(1);
                end else begin
                    out_col_next = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // Line memory read stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= step_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_h_reg    <= h_sel;
            p1_addr_reg <= in_col_reg;
            p1_ctrl_reg <= ctrl;
        end
    end

    gbs_line_buf #(
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (step_go),
        .rd_addr (in_col_reg),
        .wr_en   (shift_en),
        .wr_addr (p1_addr_reg),
        .wr_data (p1_h_reg),
        .older_q (older_q),
        .newer_q (newer_q)
    );

    // Window cells: the new column enters the rightmost cell and moves left.
    assign shift_en = adv && p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg && p1_ctrl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_ctrl_reg <= p1_ctrl_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cell_mask[k].row_top_off = p2_ctrl_reg.top_off;
            cell_mask[k].row_bot_off = p2_ctrl_reg.bot_off;
            cell_mask[k].col_off     = 1'b0;
        end
        cell_mask[0].col_off = p2_ctrl_reg.left_off;
        cell_mask[2].col_off = p2_ctrl_reg.right_off;
    end

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k == 2) begin : g_head
            gbs_col_cell #(
                .HEIGHT_BITS (HEIGHT_BITS)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .top_in   (older_q),
                .mid_in   (newer_q),
                .bot_in   (p1_h_reg),
                .mask     (cell_mask[k]),
                .top_out  (cell_top[k]),
                .mid_out  (cell_mid[k]),
                .bot_out  (cell_bot[k]),
                .col_sum  (cell_sum[k])
            );
        end else begin : g_body
            gbs_col_cell #(
                .HEIGHT_BITS (HEIGHT_BITS)
            ) u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .top_in   (cell_top[k+1]),
                .mid_in   (cell_mid[k+1]),
                .bot_in   (cell_bot[k+1]),
                .mask     (cell_mask[k]),
                .top_out  (cell_top[k]),
                .mid_out  (cell_mid[k]),
                .bot_out  (cell_bot[k]),
                .col_sum  (cell_sum[k])
            );
        end
    end

    // Neighborhood sum stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (adv) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_sum_reg  <= SUM_W'(cell_sum[0]) + SUM_W'(cell_sum[1]) + SUM_W'(cell_sum[2]);
            p3_last_reg <= p2_ctrl_reg.last;
        end
    end

    gbs_div9 #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_div9 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (p3_valid_reg),
        .in_sum    (p3_sum_reg),
        .in_last   (p3_last_reg),
        .out_valid (res_valid),
        .out_quot  (res_quot),
        .out_last  (res_last)
    );

    // Output register with skid stage.
    assign pop  = out_valid_reg && m_ready;
    assign push = adv && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (!out_valid_reg || pop) begin
            out_data_reg <= res_quot;
            out_last_reg <= res_last;
        end else begin
            skid_data_reg <= res_quot;
            skid_last_reg <= res_last;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_smoothed = out_data_reg;
    assign m_last     = out_last_reg;

endmodule

// ===== design/gbs_checker.sv =====
// Port-level checks of the grid box smoothing unit, bound to its top level.
// Depends on gbs_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "grid_box_smoothing_3x3_unit_macros.svh"

module gbs_checker #(
    parameter int HEIGHT_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [HEIGHT_BITS-1:0] m_smoothed,
    input logic                          m_last,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [gbs_pkg::PADDR_W-1:0]   paddr,
    input logic [gbs_pkg::PDATA_W-1:0]   pwdata,
    input logic [gbs_pkg::PDATA_W-1:0]   prdata,
    input logic                          pready
);

    `GBS_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `GBS_ASSERT_ALWAYS(a_ready_after_reset, aclk, !aresetn |=> s_ready)
    `GBS_ASSERT(a_out_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `GBS_ASSERT(a_out_stable, aclk, aresetn,
                m_valid && !m_ready |=> $stable(m_smoothed) && $stable(m_last))
    `GBS_ASSERT(a_rows_readback, aclk, aresetn,
                psel && penable && pwrite && pready && paddr[2] == gbs_pkg::REG_GRID_ROWS
                ##1 !pwrite && paddr[2] == gbs_pkg::REG_GRID_ROWS
                |-> prdata[gbs_pkg::ROWS_W-1:0] == $past(pwdata[gbs_pkg::ROWS_W-1:0]))

endmodule

bind grid_box_smoothing_3x3_unit gbs_checker #(
    .HEIGHT_BITS (HEIGHT_BITS)
) u_gbs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_smoothed (m_smoothed),
    .m_last     (m_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

// ===== tb/gbs_smoothing_checker.sv =====
// Checker for the grid box smoothing unit: watches the request, result and APB ports,
// predicts every smoothed height and compares each result with the oldest prediction.
// Depends on gbs_pkg for register indexes, request kinds and register widths.
`timescale 1ns / 1ps

module gbs_smoothing_checker #(
    parameter int MAX_COLS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_kind,
    input  logic signed [HEIGHT_BITS-1:0] s_height,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [HEIGHT_BITS-1:0] m_smoothed,
    input  logic                          m_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [gbs_pkg::PADDR_W-1:0]   paddr,
    input  logic [gbs_pkg::PDATA_W-1:0]   pwdata,
    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] smoothed;
        logic                          last;
    } cell_result_t;

    cell_result_t                  pending_cells[$];
    cell_result_t                  oldest;
    logic signed [HEIGHT_BITS-1:0] upper_line [MAX_COLS];
    logic signed [HEIGHT_BITS-1:0] lower_line [MAX_COLS];
    int                            nbhd [3][3];
    logic [gbs_pkg::ROWS_W-1:0]     rows_reg;
    logic [gbs_pkg::COLS_CFG_W-1:0] cols_reg;
    int                            in_r;
    int                            in_c;
    int                            out_r;
    int                            out_c;
    int                            miscount = 0;
    int                            queued = 0;

    assign mismatches  = miscount;
    assign outstanding = queued;

    task automatic restart_grid();
        in_r  = 0;
        in_c  = 0;
        out_r = 0;
        out_c = 0;
    endtask

    task automatic smooth_step(input logic kind, input logic signed [HEIGHT_BITS-1:0] h);
        int           rows;
        int           cols;
        int           hv;
        int           j;
        int           acc;
        bit           complete;
        bit           emit;
        cell_result_t res_item;
        rows = (rows_reg == 0) ? 1 : int'(rows_reg);
        cols = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg));
        complete = (in_r >= rows);
        if (kind == gbs_pkg::KIND_FLUSH && !complete) begin
            return;
        end
        hv = complete ? 0 : int'(h);
        j  = (in_c >= MAX_COLS) ? MAX_COLS - 1 : in_c;
        for (int r = 0; r < 3; r++) begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2]    = int'(upper_line[j]);
        nbhd[1][2]    = int'(lower_line[j]);
        nbhd[2][2]    = hv;
        upper_line[j] = lower_line[j];
        lower_line[j] = HEIGHT_BITS'(hv);
        emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
        in_c++;
        if (in_c >= cols) begin
            in_c = 0;
            in_r++;
        end
        if (!emit) begin
            return;
        end
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (!((r == 0 && out_r == 0) || (r == 2 && out_r + 1 >= rows) ||
                      (c == 0 && out_c == 0) || (c == 2 && out_c + 1 >= cols))) begin
                    acc += nbhd[r][c];
                end
            end
        end
        res_item.smoothed = HEIGHT_BITS'(acc / 9);
        res_item.last     = (out_r + 1 >= rows) && (out_c + 1 >= cols);
        pending_cells.push_back(res_item);
        if (res_item.last) begin
            restart_grid();
        end else begin
            out_c++;
            if (out_c >= cols) begin
                out_c = 0;
                out_r++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg = 1;
            cols_reg = 1;
            restart_grid();
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    nbhd[r][c] = 0;
                end
            end
            for (int k = 0; k < MAX_COLS; k++) begin
                upper_line[k] = '0;
                lower_line[k] = '0;
            end
            pending_cells.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_cells.size() == 0) begin
                    miscount++;
                    $display("%0t: unexpected result, expected none, got smoothed %0d last %0b",
                             $time, m_smoothed, m_last);
                end else begin
                    oldest = pending_cells.pop_front();
                    if (m_smoothed !== oldest.smoothed) begin
                        miscount++;
                        $display("%0t: smoothed expected %0d, got %0d",
                                 $time, oldest.smoothed, m_smoothed);
                    end
                    if (m_last !== oldest.last) begin
                        miscount++;
                        $display("%0t: last expected %0b, got %0b", $time, oldest.last, m_last);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                unique case (paddr)
                    {gbs_pkg::REG_GRID_ROWS, 2'b00}: begin
                        rows_reg = pwdata[gbs_pkg::ROWS_W-1:0];
                        restart_grid();
                    end
                    {gbs_pkg::REG_GRID_COLS, 2'b00}: begin
                        cols_reg = pwdata[gbs_pkg::COLS_CFG_W-1:0];
                        restart_grid();
                    end
                    default: begin
                    end
                endcase
            end else if (s_valid && s_ready) begin
                smooth_step(s_kind, s_height);
            end
        end
        queued = pending_cells.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the grid box smoothing testbench: clock, reset, APB register writes, height and
// flush requests, a stalling receiver, a watchdog and the final verdict.
// Depends on gbs_pkg, grid_box_smoothing_3x3_unit and gbs_smoothing_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_COLS      = 256;
    localparam int HEIGHT_BITS   = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TARGET_ITEMS  = 1950;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_kind;
    logic signed [HEIGHT_BITS-1:0] s_height;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [HEIGHT_BITS-1:0] m_smoothed;
    logic                          m_last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gbs_pkg::PADDR_W-1:0]   paddr;
    logic [gbs_pkg::PDATA_W-1:0]   pwdata;
    logic [gbs_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    int                            mismatches;
    int                            outstanding;
    int                            fed;
    int                            quiet;
    int                            grid_r;
    int                            grid_c;
    bit                            steady;
    bit                            squeeze_req;
    bit                            squeeze_done;

    logic signed [HEIGHT_BITS-1:0] probe_heights [9] = '{
        16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1, 16'sd0, 16'sh7FFF
    };

    grid_box_smoothing_3x3_unit #(
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_height   (s_height),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_smoothed (m_smoothed),
        .m_last     (m_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    gbs_smoothing_checker #(
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_height    (s_height),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_smoothed  (m_smoothed),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // The receiver mixes always-ready stretches, short random stalls and long hold-offs.
    initial begin
        int pick;
        m_ready      <= 1'b0;
        squeeze_done = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (squeeze_req && !squeeze_done) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                squeeze_done = 1'b1;
            end else if (pick < 15) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end else if (pick < 18) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(15, 40)) @(posedge aclk);
            end else begin
                m_ready <= (pick < 70);
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
        end
    end

    function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return 16'sh7FFF;
        end else if (r == 1) begin
            return 16'sh8000;
        end else if (r < 4) begin
            return HEIGHT_BITS'(int'($urandom_range(0, 6)) - 3);
        end
        return HEIGHT_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic put(input logic kind, input logic signed [HEIGHT_BITS-1:0] h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= kind;
        s_height <= h;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [gbs_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_grid(input int rows, input int cols);
        settle();
        write_reg(gbs_pkg::REG_GRID_ROWS, rows);
        write_reg(gbs_pkg::REG_GRID_COLS, cols);
        grid_r = (rows == 0) ? 1 : rows;
        grid_c = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    endtask

    task automatic send_part(input int count);
        for (int n = 0; n < count; n++) begin
            put(gbs_pkg::KIND_SAMPLE, pick_height());
        end
        fed += count;
    endtask

    // A whole grid, then one drain request per column plus one; some drains are samples,
    // which the block treats as flushes once the grid is complete. Noisy grids add stray flushes.
    task automatic send_grid(input bit noisy);
        for (int n = 0; n < grid_r * grid_c; n++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                put(gbs_pkg::KIND_FLUSH, pick_height());
            end
            put(gbs_pkg::KIND_SAMPLE, pick_height());
        end
        for (int k = 0; k <= grid_c; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                put(gbs_pkg::KIND_SAMPLE, pick_height());
            end else begin
                put(gbs_pkg::KIND_FLUSH, pick_height());
            end
        end
        if (noisy && $urandom_range(0, 3) == 0) begin
            put(gbs_pkg::KIND_FLUSH, pick_height());
        end
        fed += grid_r * grid_c + grid_c + 1;
    endtask

    task automatic random_phase();
        int rows;
        int cols;
        int sel;
        int grids;
        sel  = $urandom_range(0, 99);
        rows = (sel < 85) ? $urandom_range(0, 6) : ((sel < 95) ? $urandom_range(7, 16) : 65535);
        sel  = $urandom_range(0, 99);
        cols = (sel < 85) ? $urandom_range(0, 10) : $urandom_range(11, 40);
        set_grid(rows, cols);
        steady = ($urandom_range(0, 3) == 0);
        if (rows == 65535) begin
            send_part($urandom_range(1, 3 * grid_c + 4));
        end else begin
            grids = $urandom_range(1, 3);
            for (int g = 0; g < grids; g++) begin
                send_grid(1'b1);
            end
            if ($urandom_range(0, 7) == 0) begin
                send_part($urandom_range(1, grid_r * grid_c));
            end
        end
    endtask

    initial begin
        int n;
        s_valid     <= 1'b0;
        s_kind      <= gbs_pkg::KIND_SAMPLE;
        s_height    <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        aresetn     <= 1'b0;
        fed         = 0;
        steady      = 1'b0;
        squeeze_req = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A 3x3 grid of extreme heights with a flush inside the grid, a sample among
        // the drain requests and a stray flush after the final cell.
        set_grid(3, 3);
        for (int i = 0; i < 9; i++) begin
            put(gbs_pkg::KIND_SAMPLE, probe_heights[i]);
            if (i == 1) begin
                put(gbs_pkg::KIND_FLUSH, 16'sh7FFF);
            end
        end
        put(gbs_pkg::KIND_FLUSH, '0);
        put(gbs_pkg::KIND_SAMPLE, 16'sh8000);
        put(gbs_pkg::KIND_FLUSH, '0);
        put(gbs_pkg::KIND_FLUSH, '0);
        put(gbs_pkg::KIND_FLUSH, '0);

        // Zero rows and zero columns both act as a single cell.
        set_grid(0, 0);
        put(gbs_pkg::KIND_SAMPLE, 16'sh8000);
        put(gbs_pkg::KIND_FLUSH, '0);
        put(gbs_pkg::KIND_FLUSH, '0);
        fed += 17;

        set_grid(65535, 256);
        send_part(40);

        // A column count above the line depth acts as the full depth.
        set_grid(1, 511);
        send_grid(1'b0);

        // The receiver holds off while samples keep coming, so the block must stall.
        set_grid(65535, 3);
        steady      = 1'b1;
        squeeze_req = 1'b1;
        n = 0;
        while (n < 120 || !squeeze_done) begin
            put(gbs_pkg::KIND_SAMPLE, pick_height());
            n++;
        end
        fed += n;
        squeeze_req = 1'b0;

        while (fed < TARGET_ITEMS) begin
            random_phase();
        end

        settle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
